[hdl/saa_pkg.sv]
// saa_pkg: shared types, field widths and helpers of the shelf atlas allocator
// no dependencies; imported by shelf_atlas_allocator

package saa_pkg;

  localparam int RECT_W       = 11;
  localparam int LOG_W        = 4;
  localparam int PAGE_INDEX_W = 4;
  localparam int PLACE_W      = 10;
  localparam int PAGE_SIDE_W  = 11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OPEN
  } saa_state_e;

  // log2 of the smallest power of two not below v, zero for v = 0
  function automatic logic [LOG_W-1:0] ceil_log2(input logic [RECT_W-1:0] v);
    logic [LOG_W-1:0] lg;
    lg = '0;
    for (int i = 0; i < RECT_W; i++) begin
      if (v > (RECT_W'(1) << i)) lg = LOG_W'(i + 1);
    end
    return lg;
  endfunction

endpackage

[hdl/shelf_atlas_allocator.sv]
// shelf_atlas_allocator: first-fit shelf packing of rectangles into square pages
// one module with a per-page state memory and a single page-check unit
// depends on saa_pkg
//
// usage: an item (rect_width_i, rect_height_i) is taken when in_valid_i is high and
// in_stall_o low; one result item leaves on out_valid_o, taken when out_stall_i is
// low. the block holds in_stall_o high while it works on an item.
// the open pages are checked in order, one page per cycle, by one shared fit unit
// fed from the page memory's registered read port; a page that fits is held there
// until the output register is free. the first page that fits takes the rectangle;
// if none does, a new page is opened (or no_room is flagged) after all are checked.
// the block takes the next item only once the result of the last is registered.
// the result sits in an output register; a stalled receiver holds it there and the
// block finishes its next item only once that register is free.
// reset clears the page count and the handshake state; no pages are open after it.
// no_room: no page fits and either the page table is full or the new page would
// exceed MAX_SIDE; the other result fields are then zero and nothing changes.

module shelf_atlas_allocator
  import saa_pkg::*;
#(
  parameter int MAX_PAGES = 16,
  parameter int MAX_SIDE  = 1024,
  parameter int MIN_SIDE  = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [RECT_W-1:0]       rect_width_i,
  input  logic [RECT_W-1:0]       rect_height_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PAGE_INDEX_W-1:0] page_index_o,
  output logic [PLACE_W-1:0]      place_x_o,
  output logic [PLACE_W-1:0]      place_y_o,
  output logic                    opened_page_o,
  output logic [PAGE_SIDE_W-1:0]  page_side_o,
  output logic                    no_room_o
);

  localparam int IDX_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int LG_W   = $clog2(SIDE_W);
  localparam int AW     = ((SIDE_W > RECT_W) ? SIDE_W : RECT_W) + 1;
  localparam int ENT_W  = LG_W + 3 * SIDE_W;
  localparam int LG_MIN = $clog2(MIN_SIDE);
  localparam int LG_MAX = $clog2(MAX_SIDE + 1) - 1;

  saa_state_e state_q, state_d;

  logic [CNT_W-1:0]  page_count_q, page_count_d;
  logic [IDX_W-1:0]  eval_idx_q, eval_idx_d;
  logic [RECT_W-1:0] w_q, h_q;

  // page memory: {log2 side, cursor_x, row_top, next_row_top}
  logic [ENT_W-1:0] mem_q [MAX_PAGES];
  logic [ENT_W-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;

  logic [LG_W-1:0]   rd_lg;
  logic [SIDE_W-1:0] rd_x, rd_y, rd_ny;
  logic [AW-1:0]     side, w_ext, h_ext, x_ext, y_ext, ny_ext;
  logic [AW-1:0]     x_plus_w, y_plus_h, ny_plus_h;
  logic              size_ok, fits_cur, fits_new, fit, last_page, full, out_free;

  logic [LOG_W-1:0] lg_w, lg_h, lg_wh, lg_new;
  logic [AW-1:0]    side_new;
  logic             can_open;

  logic                    res_load;
  logic [PAGE_INDEX_W-1:0] res_index;
  logic [PLACE_W-1:0]      res_x, res_y;
  logic                    res_opened, res_no_room;
  logic [PAGE_SIDE_W-1:0]  res_side;

  // shared fit unit on the page read last cycle
  assign {rd_lg, rd_x, rd_y, rd_ny} = rd_q;
  assign side      = AW'(1) << rd_lg;
  assign w_ext     = AW'(w_q);
  assign h_ext     = AW'(h_q);
  assign x_ext     = AW'(rd_x);
  assign y_ext     = AW'(rd_y);
  assign ny_ext    = AW'(rd_ny);
  assign x_plus_w  = x_ext + w_ext;
  assign y_plus_h  = y_ext + h_ext;
  assign ny_plus_h = ny_ext + h_ext;
  assign size_ok   = (w_ext <= side) && (y_plus_h <= side);
  assign fits_cur  = size_ok && (x_plus_w < side);
  assign fits_new  = size_ok && !(x_plus_w < side) && (ny_plus_h <= side);
  assign fit       = fits_cur || fits_new;
  assign last_page = (CNT_W'(eval_idx_q) + CNT_W'(1)) == page_count_q;
  assign full      = page_count_q == CNT_W'(MAX_PAGES);
  assign out_free  = !out_valid_o || !out_stall_i;

  // new page side
  assign lg_w     = ceil_log2(w_q);
  assign lg_h     = ceil_log2(h_q);
  assign lg_wh    = (lg_w > lg_h) ? lg_w : lg_h;
  assign lg_new   = (LOG_W'(LG_MIN) > lg_wh) ? LOG_W'(LG_MIN) : lg_wh;
  assign side_new = AW'(1) << lg_new;
  assign can_open = !full && (lg_new <= LOG_W'(LG_MAX));

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      page_count_q <= '0;
      eval_idx_q   <= '0;
    end else begin
      state_q      <= state_d;
      page_count_q <= page_count_d;
      eval_idx_q   <= eval_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      w_q <= rect_width_i;
      h_q <= rect_height_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d      = state_q;
    page_count_d = page_count_q;
    eval_idx_d   = eval_idx_q;
    rd_addr      = '0;
    mem_we       = 1'b0;
    mem_waddr    = eval_idx_q;
    mem_wdata    = rd_q;
    res_load     = 1'b0;
    res_index    = '0;
    res_x        = '0;
    res_y        = '0;
    res_opened   = 1'b0;
    res_side     = '0;
    res_no_room  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        eval_idx_d = '0;
        if (in_valid_i) begin
          state_d = (page_count_q == '0) ? ST_OPEN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr = fit ? eval_idx_q : eval_idx_q + IDX_W'(1);
        if (fit) begin
          if (out_free) begin
            mem_we    = 1'b1;
            res_load  = 1'b1;
            res_index = PAGE_INDEX_W'(eval_idx_q);
            res_side  = PAGE_SIDE_W'(side);
            if (fits_cur) begin
              mem_wdata = {rd_lg, SIDE_W'(x_plus_w), rd_y,
                           (y_plus_h > ny_ext) ? SIDE_W'(y_plus_h) : rd_ny};
              res_x     = PLACE_W'(rd_x);
              res_y     = PLACE_W'(rd_y);
            end else begin
              mem_wdata = {rd_lg, SIDE_W'(w_q), rd_ny, SIDE_W'(ny_plus_h)};
              res_y     = PLACE_W'(rd_ny);
            end
            state_d = ST_IDLE;
          end
        end else if (last_page) begin
          state_d = ST_OPEN;
        end else begin
          eval_idx_d = eval_idx_q + IDX_W'(1);
        end
      end
      ST_OPEN: begin
        if (out_free) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
          if (can_open) begin
            mem_we       = 1'b1;
            mem_waddr    = page_count_q[IDX_W-1:0];
            mem_wdata    = {LG_W'(lg_new), SIDE_W'(w_q), SIDE_W'(0), SIDE_W'(h_q)};
            page_count_d = page_count_q + CNT_W'(1);
            res_index    = PAGE_INDEX_W'(page_count_q);
            res_opened   = 1'b1;
            res_side     = PAGE_SIDE_W'(side_new);
          end else begin
            res_no_room = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (res_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      page_index_o  <= res_index;
      place_x_o     <= res_x;
      place_y_o     <= res_y;
      opened_page_o <= res_opened;
      page_side_o   <= res_side;
      no_room_o     <= res_no_room;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_count_q <= CNT_W'(MAX_PAGES))
    else $error("page count beyond table size");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (page_count_q == $past(page_count_q) ||
              page_count_q == $past(page_count_q) + CNT_W'(1)))
    else $error("page count moved by more than one");

  a_no_room_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_room_o |-> page_index_o == '0 && place_x_o == '0 &&
      place_y_o == '0 && !opened_page_o && page_side_o == '0)
    else $error("no_room item with nonzero fields");

  a_open_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && opened_page_o |-> place_x_o == '0 && place_y_o == '0 && !no_room_o)
    else $error("new page item not at page corner");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !res_load)
    else $error("result loaded over a stalled item");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for shelf_atlas_allocator, first-fit shelf packing of rectangles
// holds its own packing predictor and random valid/stall traffic; depends on saa_pkg

module tb
  import saa_pkg::*;
();

  localparam int PAGES      = 16;
  localparam int SIDE_MAX   = 1024;
  localparam int SIDE_MIN   = 64;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 1300;

  typedef struct packed {
    logic [PAGE_INDEX_W-1:0] page;
    logic [PLACE_W-1:0]      x;
    logic [PLACE_W-1:0]      y;
    logic                    opened;
    logic [PAGE_SIDE_W-1:0]  side;
    logic                    no_room;
  } placement_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [RECT_W-1:0]       rect_width_i;
  logic [RECT_W-1:0]       rect_height_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [PAGE_INDEX_W-1:0] page_index_o;
  logic [PLACE_W-1:0]      place_x_o;
  logic [PLACE_W-1:0]      place_y_o;
  logic                    opened_page_o;
  logic [PAGE_SIDE_W-1:0]  page_side_o;
  logic                    no_room_o;

  shelf_atlas_allocator #(
    .MAX_PAGES(PAGES),
    .MAX_SIDE (SIDE_MAX),
    .MIN_SIDE (SIDE_MIN)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .page_index_o (page_index_o),
    .place_x_o    (place_x_o),
    .place_y_o    (place_y_o),
    .opened_page_o(opened_page_o),
    .page_side_o  (page_side_o),
    .no_room_o    (no_room_o)
  );

  // packing state of the predictor
  int unsigned open_pages;
  int unsigned side_log[PAGES];
  int unsigned cur_x[PAGES];
  int unsigned row_y[PAGES];
  int unsigned next_row_y[PAGES];

  placement_t  pending_places[$];
  int unsigned rects_taken;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned stall_left;
  bit          quiet;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int unsigned pow2_exponent(input int unsigned v);
    int unsigned lg;
    lg = 0;
    while (lg < 20 && (1 << lg) < v) lg++;
    return lg;
  endfunction

  function automatic bit fit_in_page(input int unsigned p, input int unsigned w,
                                     input int unsigned h, output int unsigned px,
                                     output int unsigned py);
    int unsigned side;
    side = 1 << side_log[p];
    px = 0;
    py = 0;
    if (w > side || row_y[p] + h > side) return 1'b0;
    if (cur_x[p] + w < side) begin
      px = cur_x[p];
      py = row_y[p];
      cur_x[p] = cur_x[p] + w;
      if (row_y[p] + h > next_row_y[p]) next_row_y[p] = row_y[p] + h;
      return 1'b1;
    end
    if (next_row_y[p] + h > side) return 1'b0;
    py = next_row_y[p];
    row_y[p] = next_row_y[p];
    next_row_y[p] = next_row_y[p] + h;
    cur_x[p] = w;
    return 1'b1;
  endfunction

  function automatic placement_t place_rect(input int unsigned w, input int unsigned h);
    placement_t  res;
    int unsigned p;
    int unsigned px;
    int unsigned py;
    int unsigned lg;
    bit          ok;
    bit          opened;
    res = '0;
    ok = 1'b0;
    opened = 1'b0;
    px = 0;
    py = 0;
    for (p = 0; p < open_pages; p++) begin
      if (fit_in_page(p, w, h, px, py)) begin
        ok = 1'b1;
        break;
      end
    end
    if (!ok && open_pages < PAGES) begin
      lg = pow2_exponent(w);
      if (pow2_exponent(h) > lg) lg = pow2_exponent(h);
      if (pow2_exponent(SIDE_MIN) > lg) lg = pow2_exponent(SIDE_MIN);
      if ((1 << lg) <= SIDE_MAX) begin
        p = open_pages;
        side_log[p] = lg;
        cur_x[p] = 0;
        row_y[p] = 0;
        next_row_y[p] = 0;
        open_pages = open_pages + 1;
        ok = fit_in_page(p, w, h, px, py);
        opened = 1'b1;
      end
    end
    if (!ok) begin
      res.no_room = 1'b1;
    end else begin
      res.page   = PAGE_INDEX_W'(p);
      res.x      = PLACE_W'(px);
      res.y      = PLACE_W'(py);
      res.opened = opened;
      res.side   = PAGE_SIDE_W'(1 << side_log[p]);
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int unsigned burst_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_gap();
    if (quiet || $urandom_range(0, 99) < 55) return 0;
    return burst_len();
  endfunction

  function automatic int unsigned rand_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 64) return $urandom_range(0, 24);
    if (r < 86) return $urandom_range(25, 160);
    if (r < 90) return 1 << $urandom_range(0, 10);
    if (r < 96) return $urandom_range(161, 1024);
    return $urandom_range(1025, 2047);
  endfunction

  // result checking, prediction at input accept, and the idle watchdog
  always @(posedge clk_i) begin
    placement_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      if (pending_places.size() == 0) begin
        $display("%0t: result item with none expected, expected none, actual page %0d",
                 $time, page_index_o);
        mismatches++;
      end else begin
        want = pending_places.pop_front();
        check_field("page_index", 32'(want.page), 32'(page_index_o));
        check_field("place_x", 32'(want.x), 32'(place_x_o));
        check_field("place_y", 32'(want.y), 32'(place_y_o));
        check_field("opened_page", 32'(want.opened), 32'(opened_page_o));
        check_field("page_side", 32'(want.side), 32'(page_side_o));
        check_field("no_room", 32'(want.no_room), 32'(no_room_o));
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      moved = 1'b1;
      pending_places = {pending_places,
                        place_rect(32'(rect_width_i), 32'(rect_height_i))};
      rects_taken++;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (!quiet && $urandom_range(0, 99) < 30) stall_left = burst_len();
    end
  end

  task automatic send_rect(input int unsigned w, input int unsigned h);
    int unsigned gap;
    int unsigned taken_before;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rect_width_i  <= RECT_W'(w);
    rect_height_i <= RECT_W'(h);
    taken_before = rects_taken;
    do @(negedge clk_i); while (rects_taken == taken_before);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_places.size() != 0);
  endtask

  task automatic test_directed();
    quiet = 1'b1;
    send_rect(0, 0);
    send_rect(10, 20);
    send_rect(53, 5);
    send_rect(1, 1);
    send_rect(64, 64);
    send_rect(65, 1);
    send_rect(1024, 1024);
    quiet = 1'b0;
    send_rect(1025, 3);
    send_rect(3, 2047);
    send_rect(2047, 2047);
    send_rect(0, 1024);
    send_rect(1023, 1023);
    send_rect(1024, 0);
    send_rect(0, 2047);
    send_rect(2047, 0);
    send_rect(128, 127);
    send_rect(63, 63);
    send_rect(1, 0);
    send_rect(1365, 682);
    send_rect(682, 1365);
    drain_results();
  endtask

  task automatic test_random();
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == RAND_ITEMS / 2) drain_results();
      send_rect(rand_dim(), rand_dim());
    end
    quiet = 1'b0;
    drain_results();
  endtask

  task automatic test_full_table();
    repeat (20) send_rect(1024, 1024);
    send_rect(0, 0);
    send_rect(1, 1);
    send_rect(2047, 0);
    send_rect(0, 2047);
    send_rect(5, 5);
    drain_results();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    rect_width_i  = '0;
    rect_height_i = '0;
    out_stall_i   = 1'b0;
    stall_left    = 0;
    quiet         = 1'b0;
    open_pages    = 0;
    rects_taken   = 0;
    mismatches    = 0;
    idle_cycles   = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random();
    test_full_table();
    repeat (30) @(negedge clk_i);
    if (mismatches == 0 && pending_places.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
